FILE: hw/rtl/ctrs_pkg.sv
// Shared types and constants for the cache tag replacement block.
package ctrs_pkg;

    localparam int LINES      = 64;
    localparam int LINE_W     = $clog2(LINES);
    localparam int CNT_W      = LINE_W + 1;
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int LG_MAX     = LINE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ASSOC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINES  = 2'd3;

    localparam logic [1:0] ASSOC_DIRECT = 2'd0;
    localparam logic [1:0] ASSOC_FOUR   = 2'd1;
    localparam logic [1:0] ASSOC_FULL   = 2'd2;

    localparam logic [1:0] POL_FIFO     = 2'd0;
    localparam logic [1:0] POL_LRU      = 2'd1;
    localparam logic [1:0] POL_FRONT    = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic setup;      // latch tag and set, compute set geometry
        logic rd_issue;   // issue tag read at scan pointer
        logic rd_check;   // compare returned tag
        logic sh_issue;   // read source entry for a move
        logic sh_write;   // write moved/new entry
        logic finish;     // update fill count, load output
    } ctrs_cmd_t;

    typedef struct packed {
        logic scan_done;  // all filled positions read
        logic move_done;  // shift pass complete
        logic clearing;   // fill count store being cleared
    } ctrs_sts_t;

endpackage

FILE: hw/rtl/ctrs_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module ctrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/ctrs_ctrl.sv
// Sequencer for lookup and replacement passes.
module ctrs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             out_busy,
    input  ctrs_pkg::ctrs_sts_t sts,
    output ctrs_pkg::ctrs_cmd_t cmd,
    output logic             idle
);
    import ctrs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SHRD  = 6'b001000,
        S_SHWR  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next; // read in flight during scan

    always_comb
    begin
        state_next = state_reg;
        pend_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.rd_check = pend_reg;
                if (!sts.scan_done)
                begin
                    cmd.rd_issue = 1'b1;
                    pend_next    = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = S_SHRD;
                end
            end
            S_SHRD:
            begin
                if (sts.move_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.sh_issue = 1'b1;
                    state_next   = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.sh_write = 1'b1;
                state_next   = S_SHRD;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE) && !sts.clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end
endmodule

FILE: hw/rtl/ctrs_dp.sv
// Address split, tag scan and order-shift datapath.
module ctrs_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_fire,
    input  logic [ctrs_pkg::ADDR_W-1:0] in_addr,
    input  logic                        cfg_we,
    input  logic [ctrs_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ctrs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  ctrs_pkg::ctrs_cmd_t         cmd,
    output ctrs_pkg::ctrs_sts_t         sts,
    output logic                        res_evicted,
    output logic [ctrs_pkg::TAG_W-1:0]  res_tag
);
    import ctrs_pkg::*;

    logic [1:0] assoc_reg, policy_reg;
    logic [4:0] off_reg;
    logic [2:0] lcl_reg;

    // fill count store clearing pass, one set per cycle
    logic              clr_reg;
    logic [LINE_W-1:0] clr_ptr_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [LINE_W-1:0] set_reg, base_reg;
    logic [CNT_W-1:0]  ways_reg, fillv_reg;
    logic [CNT_W-1:0]  ptr_reg, chk_reg, pos_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  mv_reg, mv_end_reg;
    logic              mv_dir_reg;   // 1: entry i <= entry i+1, 0: entry i <= entry i-1
    logic              evict_reg;
    logic [TAG_W-1:0]  victim_reg;
    logic [TAG_W-1:0]  first_reg, last_reg;  // oldest and newest tag seen by the scan
    logic              plan_reg;             // move pass planned for this item

    // geometry
    logic [ADDR_W-1:0] addr_src;
    logic [4:0] off_c;
    logic [2:0] lg_c;
    logic [2:0] idx_bits;
    logic [CNT_W-1:0] ways_c;
    logic [5:0] sh_c;
    logic [ADDR_W-1:0] tag_c;
    logic [LINE_W-1:0] set_c;
    logic [ADDR_W-1:0] set_full;

    always_comb
    begin
        // set index follows the incoming address so the fill count read lands at setup
        addr_src = in_fire ? in_addr : addr_reg;
        off_c = (off_reg > 5'd16) ? 5'd16 : off_reg;
        lg_c  = (lcl_reg < 3'd2) ? 3'd2 : ((lcl_reg > 3'(LG_MAX)) ? 3'(LG_MAX) : lcl_reg);
        priority if (assoc_reg == ASSOC_DIRECT)
        begin
            idx_bits = lg_c;
            ways_c   = CNT_W'(1);
        end
        else if (assoc_reg == ASSOC_FOUR)
        begin
            idx_bits = lg_c - 3'd2;
            ways_c   = CNT_W'(4);
        end
        else
        begin
            idx_bits = 3'd0;
            ways_c   = CNT_W'(1) << lg_c;
        end
        sh_c     = 6'(off_c) + 6'(idx_bits);
        tag_c    = addr_src >> sh_c;
        set_full = (addr_src >> off_c) & ((ADDR_W'(1) << idx_bits) - ADDR_W'(1));
        set_c    = set_full[LINE_W-1:0];
    end

    // tag RAM
    logic              ram_we;
    logic [LINE_W-1:0] ram_wa, ram_ra;
    logic [TAG_W-1:0]  ram_wd, ram_rd;

    ctrs_ram #(.WIDTH(TAG_W), .DEPTH(LINES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_wa),
        .wdata (ram_wd),
        .raddr (ram_ra),
        .rdata (ram_rd)
    );

    logic [CNT_W-1:0] mv_src;
    logic             mv_last;
    always_comb
    begin
        mv_src  = mv_dir_reg ? (mv_reg + CNT_W'(1)) : (mv_reg - CNT_W'(1));
        mv_last = (mv_reg == mv_end_reg);
        ram_ra  = cmd.rd_issue ? (base_reg + ptr_reg[LINE_W-1:0])
                               : (base_reg + mv_src[LINE_W-1:0]);
        ram_we  = cmd.sh_write;
        ram_wa  = base_reg + mv_reg[LINE_W-1:0];
        ram_wd  = mv_last ? tag_reg : ram_rd;
        sts.scan_done = (ptr_reg == fillv_reg);
        sts.move_done = (mv_reg == {CNT_W{1'b1}});
        sts.clearing  = clr_reg;
    end

    // fill count RAM
    logic              fill_we;
    logic [LINE_W-1:0] fill_wa;
    logic [CNT_W-1:0]  fill_wd, fill_rd;

    always_comb
    begin
        fill_we = clr_reg || (cmd.finish && !hit_reg && (fillv_reg < ways_reg));
        fill_wa = clr_reg ? clr_ptr_reg : set_reg;
        fill_wd = clr_reg ? '0 : (fillv_reg + CNT_W'(1));
    end

    ctrs_ram #(.WIDTH(CNT_W), .DEPTH(LINES)) u_fill (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_wa),
        .wdata (fill_wd),
        .raddr (set_c),
        .rdata (fill_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assoc_reg   <= 2'd0;
            policy_reg  <= 2'd0;
            off_reg     <= 5'd4;
            lcl_reg     <= 3'd6;
            clr_reg     <= 1'b1;
            clr_ptr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_ASSOC:  assoc_reg  <= cfg_data[1:0];
                    REG_POLICY: policy_reg <= cfg_data[1:0];
                    REG_OFFSET: off_reg    <= cfg_data;
                    REG_LINES:  lcl_reg    <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (cfg_we && (cfg_idx == REG_ASSOC || cfg_idx == REG_LINES))
            begin
                clr_reg     <= 1'b1;
                clr_ptr_reg <= '0;
            end
            else if (clr_reg)
            begin
                clr_ptr_reg <= clr_ptr_reg + LINE_W'(1);
                if (clr_ptr_reg == LINE_W'(LINES - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            addr_reg <= in_addr;
        end
        if (cmd.setup)
        begin
            tag_reg   <= tag_c[TAG_W-1:0];
            set_reg   <= set_c;
            base_reg  <= LINE_W'(32'(set_c) * 32'(ways_c));
            ways_reg  <= ways_c;
            fillv_reg <= (fill_rd > ways_c) ? ways_c : fill_rd;
            ptr_reg   <= '0;
            chk_reg   <= '0;
            hit_reg   <= 1'b0;
            pos_reg   <= '0;
            mv_reg    <= {CNT_W{1'b1}};
        end
        if (cmd.rd_issue)
        begin
            ptr_reg <= ptr_reg + CNT_W'(1);
        end
        if (cmd.rd_check)
        begin
            chk_reg <= chk_reg + CNT_W'(1);
            if (ram_rd == tag_reg)
            begin
                hit_reg <= 1'b1;
                pos_reg <= chk_reg;
            end
            if (chk_reg == '0)
            begin
                first_reg <= ram_rd;
            end
            if (chk_reg == fillv_reg - CNT_W'(1))
            begin
                last_reg <= ram_rd;
            end
        end
        // plan the move pass once the scan ends
        if (!cmd.rd_check && !cmd.rd_issue && sts.scan_done && !cmd.setup
            && mv_reg == {CNT_W{1'b1}} && !cmd.finish && !cmd.sh_issue && !cmd.sh_write
            && !plan_reg)
        begin
            evict_reg  <= 1'b0;
            victim_reg <= '0;
            if (hit_reg)
            begin
                if (policy_reg == POL_LRU)
                begin
                    mv_reg     <= pos_reg;
                    mv_end_reg <= fillv_reg - CNT_W'(1);
                    mv_dir_reg <= 1'b1;
                end
            end
            else if (fillv_reg < ways_reg)
            begin
                mv_reg     <= fillv_reg;
                mv_end_reg <= fillv_reg;
                mv_dir_reg <= 1'b1;
            end
            else if (policy_reg == POL_FRONT)
            begin
                evict_reg  <= 1'b1;
                victim_reg <= last_reg;
                mv_reg     <= ways_reg - CNT_W'(1);
                mv_end_reg <= '0;
                mv_dir_reg <= 1'b0;
            end
            else
            begin
                evict_reg  <= 1'b1;
                victim_reg <= first_reg;
                mv_reg     <= '0;
                mv_end_reg <= ways_reg - CNT_W'(1);
                mv_dir_reg <= 1'b1;
            end
        end
        if (cmd.sh_write)
        begin
            mv_reg <= mv_last ? {CNT_W{1'b1}} : mv_src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_reg <= 1'b0;
        end
        else if (cmd.setup)
        begin
            plan_reg <= 1'b0;
        end
        else if (!cmd.rd_check && !cmd.rd_issue && sts.scan_done)
        begin
            plan_reg <= 1'b1;
        end
    end

    assign res_evicted = evict_reg;
    assign res_tag     = evict_reg ? victim_reg : '0;
endmodule

FILE: hw/rtl/cache_tag_replacement_sim_top.sv
// Top level: stream ports, controller, datapath and output register.
// Each address passes through setup, a scan of the filled entries of its set, one read
// and one write per moved entry, and a done state that waits for a free output register.
// One address is in flight at a time; the next is accepted once the controller is idle again.
// Reset: asynchronous active low; a clearing pass then empties every set, as after a
// write to REG_ASSOC or REG_LINES; input is held off during the pass.
module cache_tag_replacement_sim_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] address
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] evicted, [32:1] victim_tag, [39:33] zero
    input  logic        cfg_we,
    input  logic [ctrs_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ctrs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ctrs_pkg::*;

    ctrs_cmd_t cmd;
    ctrs_sts_t sts;
    logic idle, in_fire, res_ev;
    logic [TAG_W-1:0] res_tag;
    logic out_v_reg;
    logic [39:0] out_d_reg;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;

    ctrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_v_reg && !m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle)
    );

    ctrs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_addr     (s_tdata),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .res_evicted (res_ev),
        .res_tag     (res_tag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_v_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_d_reg <= {7'd0, res_tag, res_ev};
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_v_reg || m_tready))
        else $error("result overwritten while pending");

    a_no_evict_tag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == '0)
        else $error("victim tag set without eviction");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> cmd.setup)
        else $error("accepted item not set up");
endmodule

FILE: tb/tb.sv
// Self-checking testbench for the cache tag replacement block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ctrs_pkg::*;

    typedef struct packed {
        logic        evicted;
        logic [31:0] victim_tag;
    } evict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [31:0] tags [LINES];
    int          fill [LINES];
    logic [1:0]  p_assoc = ASSOC_DIRECT;
    logic [1:0]  p_policy = POL_FIFO;
    logic [4:0]  p_offset = 5'd4;
    logic [2:0]  p_lines = 3'd6;

    evict_t      evict_q[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [31:0] addr_pool [16];

    cache_tag_replacement_sim_top i_dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic void flush_sets();
        for (int i = 0; i < LINES; i++)
            fill[i] = 0;
    endfunction

    function automatic evict_t predict_evict(input logic [31:0] a);
        int lg, off, ib, ways, set, base, f, pos;
        logic hit;
        logic [31:0] tag;
        evict_t r;
        r = '0;
        lg = (p_lines < 2) ? 2 : ((p_lines > LG_MAX) ? LG_MAX : int'(p_lines));
        off = (p_offset > 16) ? 16 : int'(p_offset);
        if (p_assoc == ASSOC_DIRECT)
        begin
            ib = lg;
            ways = 1;
        end
        else if (p_assoc == ASSOC_FOUR)
        begin
            ib = lg - 2;
            ways = 4;
        end
        else
        begin
            ib = 0;
            ways = 1 << lg;
        end
        tag = a >> (off + ib);
        set = int'((a >> off) & ((32'd1 << ib) - 1));
        base = set * ways;
        f = (fill[set] > ways) ? ways : fill[set];
        hit = 1'b0;
        pos = 0;
        for (int i = 0; i < f; i++)
            if (tags[base + i] == tag)
            begin
                hit = 1'b1;
                pos = i;
            end
        if (hit)
        begin
            if (p_policy == POL_LRU)
            begin
                for (int i = pos; i + 1 < f; i++)
                    tags[base + i] = tags[base + i + 1];
                tags[base + f - 1] = tag;
            end
        end
        else if (f < ways)
        begin
            tags[base + f] = tag;
            f++;
        end
        else if (p_policy == POL_FRONT)
        begin
            r = {1'b1, tags[base + ways - 1]};
            for (int i = ways - 1; i > 0; i--)
                tags[base + i] = tags[base + i - 1];
            tags[base] = tag;
        end
        else
        begin
            r = {1'b1, tags[base]};
            for (int i = 0; i + 1 < ways; i++)
                tags[base + i] = tags[base + i + 1];
            tags[base + ways - 1] = tag;
        end
        fill[set] = f;
        return r;
    endfunction

    // receiver: random stall, compare each transfer with the oldest prediction
    always @(posedge clk)
    begin
        evict_t e;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (evict_q.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end
            else
            begin
                e = evict_q.pop_front();
                if (m_tdata[0] !== e.evicted)
                begin
                    $error("evicted: expected %0d actual %0d", e.evicted, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[32:1] !== e.victim_tag)
                begin
                    $error("victim_tag: expected %h actual %h", e.victim_tag, m_tdata[32:1]);
                    errors++;
                end
            end
        end
    end

    task automatic send_address(input logic [31:0] a);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        s_tvalid <= 1'b1;
        s_tdata <= a;
        do
            @(posedge clk);
        while (!s_tready);
        evict_q.push_back(predict_evict(a));
    endtask

    // stop sending, let all results arrive and the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (evict_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ASSOC:
            begin
                p_assoc = val[1:0];
                flush_sets();
            end
            REG_POLICY: p_policy = val[1:0];
            REG_OFFSET: p_offset = val;
            REG_LINES:
            begin
                p_lines = val[2:0];
                flush_sets();
            end
            default: ;
        endcase
    endtask

    task automatic configure(input logic [4:0] assoc, input logic [4:0] pol,
                             input logic [4:0] off, input logic [4:0] lg);
        drain();
        write_reg(REG_ASSOC, assoc);
        write_reg(REG_POLICY, pol);
        write_reg(REG_OFFSET, off);
        write_reg(REG_LINES, lg);
    endtask

    // reset geometry: direct mapped, 16 byte blocks, 64 lines
    task automatic test_direct_fifo();
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);
        send_address(32'h0000_000F);
        send_address(32'h0000_0400);
        send_address(32'hFFFF_FBFF);
    endtask

    // one set of four ways, LRU; hit moves way to newest
    task automatic test_four_way_lru();
        configure(5'(ASSOC_FOUR), 5'(POL_LRU), 5'd0, 5'd2);
        for (int i = 1; i <= 4; i++)
            send_address(32'(i));
        send_address(32'd1);
        send_address(32'd5);
        send_address(32'd6);
    endtask

    // evict last/insert front, clamped block size and line count
    task automatic test_front_insert();
        configure(5'(ASSOC_FULL), 5'(POL_FRONT), 5'd31, 5'd0);
        for (int i = 1; i <= 5; i++)
            send_address(32'(i) << 16);
        send_address(32'h0001_0005);
        send_address(32'h0006_0000);
    endtask

    // unused codes, line count above max, policy change keeps contents
    task automatic test_odd_codes();
        configure(5'd3, 5'd3, 5'd16, 5'd7);
        for (int i = 0; i < 4; i++)
            send_address(32'(i) << 16);
        drain();
        write_reg(REG_POLICY, 5'(POL_LRU));
        send_address(32'h0000_0000);
        send_address(32'h0004_0000);
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct);
        logic [31:0] a;
        logic [4:0] off;
        drain();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int ph = 0; ph < 10; ph++)
        begin
            case ($urandom_range(3))
                0: off = 5'd0;
                1: off = 5'd16;
                2: off = 5'($urandom_range(31));
                default: off = 5'($urandom_range(8));
            endcase
            configure(5'($urandom_range(3)), 5'($urandom_range(3)), off,
                      5'($urandom_range(7)));
            a = $urandom;
            // half the pool shares the low bits, so those land in one set
            for (int i = 0; i < 16; i++)
                addr_pool[i] = (i < 8) ? {9'($urandom_range(511)), a[22:0]} : $urandom;
            for (int n = 0; n < 40; n++)
            begin
                if ($urandom_range(9) < 7)
                    a = addr_pool[4'($urandom_range(15))]
                        ^ ($urandom & ((32'd1 << off) - 1));
                else
                    a = $urandom;
                send_address(a);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < LINES; i++)
            tags[i] = '0;
        flush_sets();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_direct_fifo();
        test_four_way_lru();
        test_front_insert();
        test_odd_codes();
        test_random(9, 83);
        test_random(83, 9);
        test_random(0, 0);
        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
